// File: hdl/pba_pkg.sv
// Shared types, codes and word helpers for the page bitmap allocator.
`default_nettype none

package pba_pkg;

   localparam int WIDE_W   = 56;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;
   localparam int MAP_BITS = 64;

   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_FREE    = 3'd1;
   localparam logic [2:0] ACT_RESERVE = 3'd2;
   localparam logic [2:0] ACT_RELEASE = 3'd3;
   localparam logic [2:0] ACT_INIT    = 3'd4;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_INVALID  = 2'd1;
   localparam logic [1:0] STS_CONFLICT = 2'd2;
   localparam logic [1:0] STS_NOMEM    = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [51:0] address;
      logic [51:0] size_bytes;
      logic [52:0] alignment;
      logic [51:0] lowest_address;
      logic [51:0] highest_address;
      logic [52:0] boundary;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [52:0] granted_address;
      logic [28:0] granted_bytes;
      logic [16:0] free_count;
      logic [16:0] reserved_count;
      logic [16:0] allocated_count;
   } rsp_type;

   // One memory word carries the same 64 pages of all four bitmaps.
   typedef struct packed {
      logic [MAP_BITS-1:0] tail;
      logic [MAP_BITS-1:0] head;
      logic [MAP_BITS-1:0] rsv;
      logic [MAP_BITS-1:0] used;
   } map_word_type;

   function automatic logic [5:0] low_bit(input logic [MAP_BITS-1:0] v);
      logic [5:0] n;
      n = 6'd63;
      for (int i = MAP_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = 6'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [6:0] pop_count(input logic [MAP_BITS-1:0] v);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < MAP_BITS; i++) begin
         n = n + 7'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [MAP_BITS-1:0] range_mask(input logic [5:0] lo,
                                                      input logic [5:0] hi);
      return ({MAP_BITS{1'b1}} << lo) & ({MAP_BITS{1'b1}} >> (6'd63 - hi));
   endfunction

endpackage

`default_nettype wire

// File: hdl/page_bitmap_allocator.sv
// Page bitmap allocator: sequencer around one map memory word per access.
`default_nettype none

// One request is in flight at a time; req_stall stays high until its response has
// been loaded into the output register. The four page bitmaps share one single-port
// memory of 64-page words, and each word access is an address step followed by a
// registered data step. Initialize rewrites every word of the extent. Free, reserve
// and release check each map word that the range touches, then update each one.
// Allocate does its set-up, then scans words for a free page, places each candidate
// for alignment and boundary, checks the words of the candidate run, and writes the
// final update; the search may retry once from the low limit. The response waits in
// its register while rsp_stall holds.
module page_bitmap_allocator #(
   parameter int MAX_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pba_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pba_pkg::rsp_type          rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [pba_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pba_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [pba_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready
);
   import pba_pkg::*;

   localparam int OFF_W     = $clog2(PAGE_BYTES);
   localparam int MAP_WORDS = (MAX_PAGES + 63) / 64;
   localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WI_W      = $clog2(MAP_WORDS + 1);
   localparam int PG_W      = $clog2(MAP_WORDS * 64 + 1);
   localparam int MW_W      = $bits(map_word_type);

   typedef enum logic [29:0] {
      ST_IDLE     = 30'h0000_0001,
      ST_INIT_CHK = 30'h0000_0002,
      ST_INIT_CLR = 30'h0000_0004,
      ST_RNG0     = 30'h0000_0008,
      ST_RNG1     = 30'h0000_0010,
      ST_RNG2     = 30'h0000_0020,
      ST_CHK_RD   = 30'h0000_0040,
      ST_CHK_EV   = 30'h0000_0080,
      ST_UPD_RD   = 30'h0000_0100,
      ST_UPD_WR   = 30'h0000_0200,
      ST_AV0      = 30'h0000_0400,
      ST_AV1      = 30'h0000_0800,
      ST_AV2      = 30'h0000_1000,
      ST_AV3      = 30'h0000_2000,
      ST_AV4      = 30'h0000_4000,
      ST_AV5      = 30'h0000_8000,
      ST_AV6      = 30'h0001_0000,
      ST_FR_TOP   = 30'h0002_0000,
      ST_NF_RD    = 30'h0004_0000,
      ST_NF_EV    = 30'h0008_0000,
      ST_AL1      = 30'h0010_0000,
      ST_AL2      = 30'h0020_0000,
      ST_BD1      = 30'h0040_0000,
      ST_BD2      = 30'h0080_0000,
      ST_ST1      = 30'h0100_0000,
      ST_ST2      = 30'h0200_0000,
      ST_RUN_RD   = 30'h0400_0000,
      ST_RUN_EV   = 30'h0800_0000,
      ST_NONE     = 30'h1000_0000,
      ST_FINISH   = 30'h2000_0000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic             ready_ff, ready_in;
   logic [51:0]      cfg_base_ff, cfg_base_in;
   logic [16:0]      cfg_pages_ff, cfg_pages_in;
   logic [51:0]      ext_base_ff, ext_base_in;
   logic [PG_W-1:0]  ext_pages_ff, ext_pages_in;
   logic [WI_W-1:0]  ext_words_ff, ext_words_in;
   logic [PG_W-1:0]  free_ff, free_in;
   logic [PG_W-1:0]  rsv_cnt_ff, rsv_cnt_in;
   logic [PG_W-1:0]  alloc_cnt_ff, alloc_cnt_in;
   logic [PG_W-1:0]  rotor_ff, rotor_in;
   logic [WI_W-1:0]  w_ff, w_in;
   logic [PG_W-1:0]  rfirst_ff, rfirst_in;
   logic [PG_W-1:0]  rlast_ff, rlast_in;
   logic [PG_W-1:0]  rpages_ff, rpages_in;
   logic [51:0]      diff_ff, diff_in;
   logic             bad_ff, bad_in;
   logic [52:0]      amask_ff, amask_in;
   logic [52:0]      bmask_ff, bmask_in;
   logic [WIDE_W-1:0] needw_ff, needw_in;
   logic [WIDE_W-1:0] firstw_ff, firstw_in;
   logic [WIDE_W-1:0] limitw_ff, limitw_in;
   logic [WIDE_W-1:0] tmp_ff, tmp_in;
   logic [WIDE_W-1:0] phys_ff, phys_in;
   logic [PG_W-1:0]  first0_ff, first0_in;
   logic [PG_W-1:0]  limit_ff, limit_in;
   logic [PG_W-1:0]  cur_ff, cur_in;
   logic [PG_W-1:0]  mid_ff, mid_in;
   logic             pass_ff, pass_in;
   logic [52:0]      gaddr_ff, gaddr_in;
   logic [28:0]      gbytes_ff, gbytes_in;

   logic             ram_we;
   map_word_type     ram_wword;
   logic [MW_W-1:0]  ram_rdata;
   map_word_type     rword;

   logic [WIDE_W-1:0]   base_pg;
   logic [WIDE_W-1:0]   apm, bpm, bnd_pg;
   logic [WI_W-1:0]     w_first, w_last, w_cur;
   logic [5:0]          lo_b, hi_b;
   logic [MAP_BITS-1:0] mask, fb, lb, occ, avail;
   logic [6:0]          pc;
   logic                chk_bad, at_last;
   logic                cfg_write;

   pba_ram #(
      .WIDTH (MW_W),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock    (clock),
      .write_en (ram_we),
      .addr     (w_ff[WA_W-1:0]),
      .wdata    (MW_W'(ram_wword)),
      .rdata    (ram_rdata)
   );

   assign rword   = map_word_type'(ram_rdata);
   assign base_pg = WIDE_W'(ext_base_ff >> OFF_W);
   assign apm     = WIDE_W'(amask_ff >> OFF_W);
   assign bpm     = WIDE_W'(bmask_ff >> OFF_W);
   assign bnd_pg  = WIDE_W'(req_ff.boundary >> OFF_W);
   assign w_first = WI_W'(rfirst_ff >> 6);
   assign w_last  = WI_W'(rlast_ff >> 6);
   assign w_cur   = WI_W'(cur_ff >> 6);
   assign at_last = (w_ff == w_last);
   assign lo_b    = (w_ff == w_first) ? rfirst_ff[5:0] : 6'd0;
   assign hi_b    = at_last ? rlast_ff[5:0] : 6'd63;
   assign mask    = range_mask(lo_b, hi_b);
   assign fb      = (w_ff == w_first) ? (MAP_BITS'(1) << rfirst_ff[5:0]) : '0;
   assign lb      = at_last ? (MAP_BITS'(1) << rlast_ff[5:0]) : '0;
   assign occ     = rword.used & mask;
   assign avail   = ~rword.used & ((w_ff == w_cur) ? ({MAP_BITS{1'b1}} << cur_ff[5:0])
                                                   : {MAP_BITS{1'b1}});
   assign pc      = pop_count(mask & ~rword.rsv);

   // Ownership checks of one map word for free, reserve and release.
   always_comb begin
      chk_bad = 1'b0;
      case (req_ff.action)
         ACT_FREE: begin
            chk_bad = (((~rword.used | rword.rsv) & mask) != '0)
                   || ((rword.head & mask & ~fb) != '0)
                   || ((rword.tail & mask & ~lb) != '0)
                   || ((fb != '0) && ((rword.head & fb) == '0))
                   || ((lb != '0) && ((rword.tail & lb) == '0));
         end
         ACT_RESERVE: chk_bad = ((rword.used & ~rword.rsv & mask) != '0);
         ACT_RELEASE: chk_bad = ((~rword.rsv & mask) != '0);
         default:     chk_bad = 1'b0;
      endcase
   end

   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_base_in  = cfg_base_ff;
      cfg_pages_in = cfg_pages_ff;
      if (cfg_write) begin
         if (csr_paddr[3]) begin
            cfg_pages_in = csr_pwdata[16:0];
         end else begin
            cfg_base_in = csr_pwdata[51:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[3] ? CSR_DW'(cfg_pages_ff) : CSR_DW'(cfg_base_ff);
   assign csr_pready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      ready_in     = ready_ff;
      ext_base_in  = ext_base_ff;
      ext_pages_in = ext_pages_ff;
      ext_words_in = ext_words_ff;
      free_in      = free_ff;
      rsv_cnt_in   = rsv_cnt_ff;
      alloc_cnt_in = alloc_cnt_ff;
      rotor_in     = rotor_ff;
      w_in         = w_ff;
      rfirst_in    = rfirst_ff;
      rlast_in     = rlast_ff;
      rpages_in    = rpages_ff;
      diff_in      = diff_ff;
      bad_in       = bad_ff;
      amask_in     = amask_ff;
      bmask_in     = bmask_ff;
      needw_in     = needw_ff;
      firstw_in    = firstw_ff;
      limitw_in    = limitw_ff;
      tmp_in       = tmp_ff;
      phys_in      = phys_ff;
      first0_in    = first0_ff;
      limit_in     = limit_ff;
      cur_in       = cur_ff;
      mid_in       = mid_ff;
      pass_in      = pass_ff;
      gaddr_in     = gaddr_ff;
      gbytes_in    = gbytes_ff;
      ram_we       = 1'b0;
      ram_wword    = rword;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               gaddr_in  = '0;
               gbytes_in = '0;
               if (req_data.action == ACT_INIT) begin
                  state_in = ST_INIT_CHK;
               end else if (!ready_ff || req_data.action > ACT_INIT) begin
                  status_in = STS_INVALID;
                  state_in  = ST_FINISH;
               end else if (req_data.action == ACT_ALLOC) begin
                  state_in = ST_AV0;
               end else begin
                  state_in = ST_RNG0;
               end
            end
         end

         ST_INIT_CHK: begin
            if (cfg_pages_ff == '0 || 32'(cfg_pages_ff) > 32'(MAX_PAGES)
                || cfg_base_ff[OFF_W-1:0] != '0) begin
               status_in = STS_INVALID;
               state_in  = ST_FINISH;
            end else begin
               ext_base_in  = cfg_base_ff;
               ext_pages_in = PG_W'(cfg_pages_ff);
               ext_words_in = WI_W'((32'(cfg_pages_ff) + 32'd63) >> 6);
               free_in      = PG_W'(cfg_pages_ff);
               rsv_cnt_in   = '0;
               alloc_cnt_in = '0;
               rotor_in     = '0;
               w_in         = '0;
               state_in     = ST_INIT_CLR;
            end
         end

         ST_INIT_CLR: begin
            // Pages past the extent in its last word are marked used and reserved.
            ram_we    = 1'b1;
            ram_wword = '0;
            if (w_ff == ext_words_ff - 1'b1) begin
               if (ext_pages_ff[5:0] != 6'd0) begin
                  ram_wword.used = {MAP_BITS{1'b1}} << ext_pages_ff[5:0];
                  ram_wword.rsv  = {MAP_BITS{1'b1}} << ext_pages_ff[5:0];
               end
               ready_in  = 1'b1;
               status_in = STS_OK;
               state_in  = ST_FINISH;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end

         ST_RNG0: begin
            bad_in   = (req_ff.size_bytes == '0)
                    || ((req_ff.address[OFF_W-1:0] | req_ff.size_bytes[OFF_W-1:0]) != '0)
                    || (req_ff.address < ext_base_ff);
            diff_in  = req_ff.address - ext_base_ff;
            state_in = ST_RNG1;
         end

         ST_RNG1: begin
            if (bad_ff || (diff_ff >> OFF_W) >= 52'(ext_pages_ff)) begin
               status_in = STS_INVALID;
               state_in  = ST_FINISH;
            end else begin
               rfirst_in = PG_W'(diff_ff >> OFF_W);
               needw_in  = WIDE_W'(req_ff.size_bytes >> OFF_W);
               state_in  = ST_RNG2;
            end
         end

         ST_RNG2: begin
            if (needw_ff > WIDE_W'(ext_pages_ff - rfirst_ff)) begin
               status_in = STS_INVALID;
               state_in  = ST_FINISH;
            end else begin
               rpages_in = PG_W'(needw_ff);
               rlast_in  = rfirst_ff + PG_W'(needw_ff) - 1'b1;
               w_in      = w_first;
               state_in  = ST_CHK_RD;
            end
         end

         ST_CHK_RD: state_in = ST_CHK_EV;

         ST_CHK_EV: begin
            if (chk_bad) begin
               status_in = STS_CONFLICT;
               state_in  = ST_FINISH;
            end else if (at_last) begin
               w_in     = w_first;
               state_in = ST_UPD_RD;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_CHK_RD;
            end
         end

         ST_UPD_RD: state_in = ST_UPD_WR;

         ST_UPD_WR: begin
            ram_we = 1'b1;
            case (req_ff.action)
               ACT_ALLOC: begin
                  ram_wword.used = rword.used | mask;
                  ram_wword.head = rword.head | fb;
                  ram_wword.tail = rword.tail | lb;
               end
               ACT_FREE: begin
                  ram_wword.used = rword.used & ~mask;
                  ram_wword.head = rword.head & ~fb;
                  ram_wword.tail = rword.tail & ~lb;
               end
               ACT_RESERVE: begin
                  ram_wword.used = rword.used | mask;
                  ram_wword.rsv  = rword.rsv | mask;
                  free_in        = free_ff - PG_W'(pc);
                  rsv_cnt_in     = rsv_cnt_ff + PG_W'(pc);
               end
               default: begin
                  ram_wword.used = rword.used & ~mask;
                  ram_wword.rsv  = rword.rsv & ~mask;
               end
            endcase
            if (at_last) begin
               status_in = STS_OK;
               state_in  = ST_FINISH;
               case (req_ff.action)
                  ACT_ALLOC: begin
                     free_in      = free_ff - rpages_ff;
                     alloc_cnt_in = alloc_cnt_ff + rpages_ff;
                     rotor_in     = (rlast_ff + 1'b1 == ext_pages_ff) ? '0
                                                                      : rlast_ff + 1'b1;
                     gaddr_in     = 53'(ext_base_ff) + (53'(rfirst_ff) << OFF_W);
                     gbytes_in    = 29'(WIDE_W'(rpages_ff) << OFF_W);
                  end
                  ACT_FREE: begin
                     free_in      = free_ff + rpages_ff;
                     alloc_cnt_in = alloc_cnt_ff - rpages_ff;
                  end
                  ACT_RELEASE: begin
                     free_in    = free_ff + rpages_ff;
                     rsv_cnt_in = rsv_cnt_ff - rpages_ff;
                  end
                  default: ;
               endcase
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_UPD_RD;
            end
         end

         ST_AV0: begin
            bad_in   = (req_ff.size_bytes == '0)
                    || (req_ff.lowest_address > req_ff.highest_address);
            amask_in = req_ff.alignment - 1'b1;
            bmask_in = req_ff.boundary - 1'b1;
            state_in = ST_AV1;
         end

         ST_AV1: begin
            if (bad_ff || req_ff.alignment == '0 || (req_ff.alignment & amask_ff) != '0
                || (req_ff.boundary != '0 && ((req_ff.boundary & bmask_ff) != '0
                    || req_ff.boundary < 53'(PAGE_BYTES)))) begin
               status_in = STS_INVALID;
               state_in  = ST_FINISH;
            end else begin
               needw_in = (WIDE_W'(req_ff.size_bytes) + WIDE_W'(PAGE_BYTES - 1)) >> OFF_W;
               state_in = ST_AV2;
            end
         end

         ST_AV2: begin
            if (needw_ff > WIDE_W'(free_ff)
                || (req_ff.boundary != '0 && needw_ff > bnd_pg)) begin
               status_in = STS_NOMEM;
               state_in  = ST_FINISH;
            end else begin
               // The limits are rounded inward to whole pages.
               firstw_in = WIDE_W'(req_ff.lowest_address >> OFF_W)
                         + WIDE_W'(req_ff.lowest_address[OFF_W-1:0] != '0);
               limitw_in = WIDE_W'(req_ff.highest_address >> OFF_W)
                         + WIDE_W'(req_ff.highest_address[OFF_W-1:0] == {OFF_W{1'b1}});
               state_in  = ST_AV3;
            end
         end

         ST_AV3: begin
            if (firstw_ff < base_pg) begin
               firstw_in = base_pg;
            end
            tmp_in   = base_pg + WIDE_W'(ext_pages_ff);
            state_in = ST_AV4;
         end

         ST_AV4: begin
            if (limitw_ff > tmp_ff) begin
               limitw_in = tmp_ff;
            end
            state_in = ST_AV5;
         end

         ST_AV5: begin
            if (firstw_ff >= limitw_ff || needw_ff > limitw_ff - firstw_ff) begin
               status_in = STS_NOMEM;
               state_in  = ST_FINISH;
            end else begin
               first0_in = PG_W'(firstw_ff - base_pg);
               limit_in  = PG_W'(limitw_ff - base_pg);
               rpages_in = PG_W'(needw_ff);
               state_in  = ST_AV6;
            end
         end

         ST_AV6: begin
            if (rotor_ff >= first0_ff && rotor_ff < limit_ff) begin
               mid_in = rotor_ff;
               cur_in = rotor_ff;
            end else begin
               mid_in = first0_ff;
               cur_in = first0_ff;
            end
            pass_in  = 1'b0;
            state_in = ST_FR_TOP;
         end

         ST_FR_TOP: begin
            if (cur_ff < limit_ff && (PG_W+1)'(cur_ff) + (PG_W+1)'(rpages_ff)
                                     <= (PG_W+1)'(limit_ff)) begin
               w_in     = w_cur;
               state_in = ST_NF_RD;
            end else begin
               state_in = ST_NONE;
            end
         end

         ST_NF_RD: begin
            if (w_ff < ext_words_ff && PG_W'({w_ff, 6'd0}) < limit_ff) begin
               state_in = ST_NF_EV;
            end else begin
               state_in = ST_NONE;
            end
         end

         ST_NF_EV: begin
            if (avail != '0) begin
               if (PG_W'({w_ff, low_bit(avail)}) < limit_ff) begin
                  phys_in  = WIDE_W'(PG_W'({w_ff, low_bit(avail)}));
                  state_in = ST_AL1;
               end else begin
                  state_in = ST_NONE;
               end
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_NF_RD;
            end
         end

         ST_AL1: begin
            phys_in  = phys_ff + base_pg;
            state_in = ST_AL2;
         end

         ST_AL2: begin
            phys_in  = (phys_ff + apm) & ~apm;
            state_in = ST_BD1;
         end

         ST_BD1: begin
            // A run that would cross the boundary moves up to the next one.
            if (req_ff.boundary != '0
                && WIDE_W'(rpages_ff) + (phys_ff & bpm) > bnd_pg) begin
               state_in = ST_BD2;
            end else begin
               state_in = ST_ST1;
            end
         end

         ST_BD2: begin
            phys_in  = (phys_ff + bpm) & ~bpm;
            state_in = ST_ST1;
         end

         ST_ST1: begin
            phys_in  = phys_ff - base_pg;
            state_in = ST_ST2;
         end

         ST_ST2: begin
            if (phys_ff >= WIDE_W'(limit_ff)
                || phys_ff + WIDE_W'(rpages_ff) > WIDE_W'(limit_ff)) begin
               state_in = ST_NONE;
            end else begin
               rfirst_in = PG_W'(phys_ff);
               rlast_in  = PG_W'(phys_ff) + rpages_ff - 1'b1;
               w_in      = WI_W'(PG_W'(phys_ff) >> 6);
               state_in  = ST_RUN_RD;
            end
         end

         ST_RUN_RD: state_in = ST_RUN_EV;

         ST_RUN_EV: begin
            if (occ != '0) begin
               cur_in   = PG_W'({w_ff, 6'd0}) + PG_W'(low_bit(occ)) + 1'b1;
               state_in = ST_FR_TOP;
            end else if (at_last) begin
               w_in     = w_first;
               state_in = ST_UPD_RD;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_RUN_RD;
            end
         end

         ST_NONE: begin
            if (!pass_ff && mid_ff != first0_ff) begin
               pass_in  = 1'b1;
               cur_in   = first0_ff;
               state_in = ST_FR_TOP;
            end else begin
               status_in = STS_NOMEM;
               state_in  = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.granted_address = gaddr_ff;
               rsp_in.granted_bytes   = gbytes_ff;
               rsp_in.free_count      = 17'(free_ff);
               rsp_in.reserved_count  = 17'(rsv_cnt_ff);
               rsp_in.allocated_count = 17'(alloc_cnt_ff);
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
         cfg_base_ff  <= '0;
         cfg_pages_ff <= 17'd1;
         free_ff      <= '0;
         rsv_cnt_ff   <= '0;
         alloc_cnt_ff <= '0;
         rotor_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ready_ff     <= ready_in;
         cfg_base_ff  <= cfg_base_in;
         cfg_pages_ff <= cfg_pages_in;
         free_ff      <= free_in;
         rsv_cnt_ff   <= rsv_cnt_in;
         alloc_cnt_ff <= alloc_cnt_in;
         rotor_ff     <= rotor_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      status_ff    <= status_in;
      ext_base_ff  <= ext_base_in;
      ext_pages_ff <= ext_pages_in;
      ext_words_ff <= ext_words_in;
      w_ff         <= w_in;
      rfirst_ff    <= rfirst_in;
      rlast_ff     <= rlast_in;
      rpages_ff    <= rpages_in;
      diff_ff      <= diff_in;
      bad_ff       <= bad_in;
      amask_ff     <= amask_in;
      bmask_ff     <= bmask_in;
      needw_ff     <= needw_in;
      firstw_ff    <= firstw_in;
      limitw_ff    <= limitw_in;
      tmp_ff       <= tmp_in;
      phys_ff      <= phys_in;
      first0_ff    <= first0_in;
      limit_ff     <= limit_in;
      cur_ff       <= cur_in;
      mid_ff       <= mid_in;
      pass_ff      <= pass_in;
      gaddr_ff     <= gaddr_in;
      gbytes_ff    <= gbytes_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // Every page of an initialized extent is free, reserved or allocated.
   a_pages_conserved: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (PG_W+2)'(free_ff) + (PG_W+2)'(rsv_cnt_ff) + (PG_W+2)'(alloc_cnt_ff)
                   == (PG_W+2)'(ext_pages_ff))
      else $error("page counts do not add up to the extent");

   a_rotor_in_extent: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> rotor_ff < ext_pages_ff)
      else $error("search rotor outside the extent");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");
`endif

endmodule

`default_nettype wire

// File: hdl/pba_ram.sv
// Generic single-port RAM with a registered read port.
`default_nettype none

module pba_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
